[rtl/rrts_pkg.sv]
// shared types and constants for the round-robin thread scheduler
// slot state codes, command codes, register indexes and the beat structs
// no dependencies
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int STATE_W = 3;
	localparam int RUN_W   = 4;
	localparam int MASK_W  = 16;
	localparam int CFG_W   = 16;

	// slot state codes
	localparam logic [STATE_W-1:0] ST_EMPTY = 3'd0;
	localparam logic [STATE_W-1:0] ST_NEW   = 3'd1;
	localparam logic [STATE_W-1:0] ST_READY = 3'd2;
	localparam logic [STATE_W-1:0] ST_RUN   = 3'd3;
	localparam logic [STATE_W-1:0] ST_SLEEP = 3'd4;
	localparam logic [STATE_W-1:0] ST_DEAD  = 3'd5;

	// command codes
	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_ADD   = 2'd1;
	localparam logic [1:0] FN_SLEEP = 2'd2;
	localparam logic [1:0] FN_KILL  = 2'd3;

	// register indexes
	localparam logic REG_SLICE_TICKS = 1'b0;
	localparam logic REG_IDLE_SLOT   = 1'b1;

	localparam logic [CFG_W-1:0] SLICE_TICKS_RESET = 16'd10;
	localparam logic [3:0]       IDLE_SLOT_RESET   = 4'd0;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [31:0] wake_at;
		logic [31:0] uptime;
	} item_t;

	typedef struct packed {
		logic              switched;
		logic [RUN_W-1:0]  run_slot;
		logic              fresh_start;
		logic              fell_to_idle;
		logic [MASK_W-1:0] reclaimed_mask;
		logic              no_thread;
	} result_t;

endpackage

[rtl/rrts_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// used for the slot state and wake time tables; no dependencies
`timescale 1ns / 1ps

module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/round_robin_thread_scheduler.sv]
// round-robin time-slice thread scheduler, state held in two rams (slot state, wake time)
// add answers the cycle after acceptance; in-range sleep and kill first read in S_OPRD
// a tick with a running thread reads in S_TRD; a switching one scans one slot per cycle
// a new command is taken in the cycle its predecessor's result is shown
// reset empties every slot at once through per-slot valid bits, no clearing pass;
// slice_ticks resets to 10 and idle_slot to 0; results cannot be stalled
`timescale 1ns / 1ps

module round_robin_thread_scheduler
	import rrts_pkg::*;
#(
	parameter int THREAD_SLOTS = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             done,
	output result_t          result,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(THREAD_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_OPRD   = 3'd1;
	localparam logic [2:0] S_TRD    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_IDLERD = 3'd4;
	localparam logic [2:0] S_PICK   = 3'd5;

	logic [2:0]              state_q, state_d;
	logic [1:0]              func_q, func_d;
	logic [SLOT_W-1:0]       slot_q, slot_d;
	logic [TIME_WIDTH-1:0]   wake_q, wake_d;
	logic [TIME_WIDTH-1:0]   now_q, now_d;
	logic [SLOT_W-1:0]       running_q, running_d;
	logic                    has_running_q, has_running_d;
	logic [CFG_W-1:0]        count_q, count_d;
	logic [CFG_W-1:0]        slice_ticks_q;
	logic [3:0]              idle_slot_q;
	logic [SLOT_W-1:0]       scan_q, scan_d;
	logic [SLOT_W-1:0]       step_q, step_d;
	logic [MASK_W-1:0]       mask_q, mask_d;
	logic [THREAD_SLOTS-1:0] valid_q;
	logic                    vld_s1;
	logic                    done_q, done_d;
	result_t                 result_q, res_d;

	logic                    st_we;
	logic [SLOT_W-1:0]       st_waddr;
	logic [STATE_W-1:0]      st_wdata;
	logic [STATE_W-1:0]      st_rdata;
	logic                    wk_we;
	logic [TIME_WIDTH-1:0]   wk_rdata;
	logic [SLOT_W-1:0]       rd_addr;
	logic [STATE_W-1:0]      rd_st;
	logic [SLOT_W-1:0]       idle_pick;
	logic                    in_range;

	rrts_ram #(.WIDTH(STATE_W), .DEPTH(THREAD_SLOTS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (rd_addr),
		.rdata (st_rdata)
	);

	rrts_ram #(.WIDTH(TIME_WIDTH), .DEPTH(THREAD_SLOTS)) u_wake_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (slot_q),
		.wdata (wake_q),
		.raddr (rd_addr),
		.rdata (wk_rdata)
	);

	// an entry never written since reset reads as empty
	assign rd_st = vld_s1 ? st_rdata : ST_EMPTY;

	assign in_range  = 32'(item.slot) < 32'(THREAD_SLOTS);
	assign idle_pick = (32'(idle_slot_q) < 32'(THREAD_SLOTS)) ? SLOT_W'(idle_slot_q) : '0;

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	function automatic logic [SLOT_W-1:0] dec_slot(input logic [SLOT_W-1:0] s);
		dec_slot = (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	always_comb begin
		logic [MASK_W-1:0] mask_v;
		logic              next_v;

		state_d       = state_q;
		func_d        = func_q;
		slot_d        = slot_q;
		wake_d        = wake_q;
		now_d         = now_q;
		running_d     = running_q;
		has_running_d = has_running_q;
		count_d       = count_q;
		scan_d        = scan_q;
		step_d        = step_q;
		mask_d        = mask_q;
		done_d        = 1'b0;
		res_d         = '0;
		st_we         = 1'b0;
		st_waddr      = slot_q;
		st_wdata      = ST_EMPTY;
		wk_we         = 1'b0;
		rd_addr       = scan_q;
		mask_v        = mask_q;
		next_v        = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d = item.func;
					slot_d = SLOT_W'(item.slot);
					wake_d = TIME_WIDTH'(item.wake_at);
					now_d  = TIME_WIDTH'(item.uptime);
					unique case (item.func)
						FN_ADD: begin
							if (in_range) begin
								st_we    = 1'b1;
								st_waddr = SLOT_W'(item.slot);
								st_wdata = ST_NEW;
								if (!has_running_q) begin
									running_d     = SLOT_W'(item.slot);
									has_running_d = 1'b1;
								end
							end
							done_d = 1'b1;
						end
						FN_SLEEP, FN_KILL: begin
							if (in_range) begin
								rd_addr = SLOT_W'(item.slot);
								state_d = S_OPRD;
							end else begin
								done_d = 1'b1;
							end
						end
						FN_TICK: begin
							if (!has_running_q) begin
								res_d.no_thread = 1'b1;
								done_d          = 1'b1;
							end else begin
								rd_addr = running_q;
								state_d = S_TRD;
							end
						end
					endcase
				end
			end
			S_OPRD: begin
				if (func_q == FN_SLEEP) begin
					if (rd_st != ST_EMPTY && rd_st != ST_DEAD) begin
						st_we    = 1'b1;
						st_wdata = ST_SLEEP;
						wk_we    = 1'b1;
					end
				end else if (rd_st != ST_EMPTY) begin
					st_we    = 1'b1;
					st_wdata = ST_DEAD;
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_TRD: begin
				// a sleeping running thread ends its slice at once
				if (rd_st == ST_SLEEP || count_q >= slice_ticks_q) begin
					if (rd_st == ST_NEW || rd_st == ST_READY || rd_st == ST_RUN) begin
						st_we    = 1'b1;
						st_waddr = running_q;
						st_wdata = ST_READY;
					end
					scan_d  = dec_slot(running_q);
					rd_addr = dec_slot(running_q);
					step_d  = SLOT_W'(1);
					mask_d  = '0;
					state_d = S_SCAN;
				end else begin
					count_d = count_q + 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				st_waddr = scan_q;
				unique case (rd_st)
					ST_SLEEP: begin
						if (now_q > wk_rdata) begin
							st_we    = 1'b1;
							st_wdata = ST_RUN;
						end else begin
							next_v = 1'b1;
						end
					end
					ST_DEAD: begin
						st_we    = 1'b1;
						st_wdata = ST_EMPTY;
						if (32'(scan_q) < 32'(MASK_W)) begin
							mask_v[4'(scan_q)] = 1'b1;
						end
						next_v = 1'b1;
					end
					ST_READY, ST_NEW: begin
						st_we    = 1'b1;
						st_wdata = ST_RUN;
					end
					default: begin
						next_v = 1'b1;
					end
				endcase
				mask_d = mask_v;
				if (!next_v) begin
					res_d.switched       = scan_q != running_q;
					res_d.fresh_start    = rd_st == ST_NEW;
					res_d.reclaimed_mask = mask_v;
					running_d = scan_q;
					count_d   = '0;
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end else if (step_q == LAST_SLOT) begin
					// every slot but the running one scanned without a runnable slot
					state_d = S_IDLERD;
				end else begin
					scan_d  = dec_slot(scan_q);
					rd_addr = dec_slot(scan_q);
					step_d  = step_q + 1'b1;
				end
			end
			S_IDLERD: begin
				rd_addr = idle_pick;
				state_d = S_PICK;
			end
			S_PICK: begin
				if (rd_st == ST_NEW || rd_st == ST_READY) begin
					st_we    = 1'b1;
					st_waddr = idle_pick;
					st_wdata = ST_RUN;
				end
				res_d.switched       = idle_pick != running_q;
				res_d.fresh_start    = rd_st == ST_NEW;
				res_d.fell_to_idle   = 1'b1;
				res_d.reclaimed_mask = mask_q;
				running_d = idle_pick;
				count_d   = '0;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.run_slot = RUN_W'(running_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			running_q     <= '0;
			has_running_q <= 1'b0;
			count_q       <= '0;
			slice_ticks_q <= SLICE_TICKS_RESET;
			idle_slot_q   <= IDLE_SLOT_RESET;
			valid_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			running_q     <= running_d;
			has_running_q <= has_running_d;
			count_q       <= count_d;
			done_q        <= done_d;
			if (st_we) begin
				valid_q[st_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SLICE_TICKS: slice_ticks_q <= cfg_data;
					REG_IDLE_SLOT:   idle_slot_q   <= cfg_data[3:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		slot_q <= slot_d;
		wake_q <= wake_d;
		now_q  <= now_d;
		scan_q <= scan_d;
		step_q <= step_d;
		mask_q <= mask_d;
		vld_s1 <= valid_q[rd_addr];
		if (done_d) begin
			result_q <= res_d;
		end
	end

endmodule
